/* rtl/tbpp_pkg.sv */
// tbpp_pkg: payload structs, codes, sizes and scroll-step functions for the
// tile background pixel pipeline; no dependencies
package tbpp_pkg;

  localparam int unsigned NametableBytes = 2048;
  localparam int unsigned PatternBytes   = 8192;
  localparam int unsigned TileSlots      = 32;
  localparam int unsigned PaletteBytes   = 32;
  localparam int unsigned NtAw           = $clog2(NametableBytes);
  localparam int unsigned PtAw           = $clog2(PatternBytes);
  localparam int unsigned SlotAw         = $clog2(TileSlots);
  localparam int unsigned PalAw          = $clog2(PaletteBytes);

  localparam logic [8:0] DotsPerLine  = 9'd341;
  localparam logic [8:0] LinesPerFrame = 9'd262;
  localparam logic [8:0] LastDot      = 9'd340;
  localparam logic [8:0] LastLine     = 9'd261;
  localparam logic [8:0] VisLines     = 9'd240;
  localparam logic [8:0] VblankLine   = 9'd241;
  localparam logic [14:0] HorizMask   = 15'h041F;
  localparam logic [14:0] VertMask    = 15'h7BE0;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_NT_WR    = 3'd1,
    KIND_PAL_WR   = 3'd2,
    KIND_PAT_WR   = 3'd3,
    KIND_LOAD_T   = 3'd4,
    KIND_LOAD_V   = 3'd5
  } kind_e;

  typedef enum logic {
    CFG_PATTERN_SELECT = 1'b0,
    CFG_VERT_MIRROR    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FETCH_TILE = 2'd0,
    FETCH_ATTR = 2'd1,
    FETCH_LO   = 2'd2,
    FETCH_HI   = 2'd3
  } fetch_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [12:0] addr;
    logic [14:0] data;
  } in_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] colour;
    logic       vblank;
    logic [8:0] dot_now;
    logic [8:0] line_now;
  } out_t;

  // fetch still waiting for memory read data
  typedef struct packed {
    logic              valid;
    fetch_e            target;
    logic [SlotAw-1:0] slot;
  } fetch_t;

  function automatic logic [14:0] coarse_x_step(input logic [14:0] v);
    logic [14:0] r;
    if (v[4:0] != 5'd31) begin
      r = v + 15'd1;
    end else begin
      r = {v[14:11], ~v[10], v[9:5], 5'd0};
    end
    return r;
  endfunction

  function automatic logic [14:0] fine_y_step(input logic [14:0] v);
    logic [14:0] r;
    r = v;
    if (v[14:12] != 3'd7) begin
      r[14:12] = v[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      if (v[9:5] < 5'd29) begin
        r[9:5] = v[9:5] + 5'd1;
      end else if (v[9:5] == 5'd29) begin
        r[9:5] = 5'd0;
        r[11]  = ~v[11];
      end else begin
        r[9:5] = 5'd0;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/tbpp_ram.sv */
// tbpp_ram: generic simple dual-port RAM, one write and one registered read
// no dependencies
module tbpp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tile_background_pixel_pipeline.sv */
// tile_background_pixel_pipeline: background fetch, scroll and pixel pipeline
// result registered for the next cycle; one transaction per cycle unless output stalls
// fetch data goes via the RAM read register into the tile, attribute and pattern registers
// async active-low reset clears counters, scroll, shifters and flags; memories are not reset
// depends on tbpp_pkg and tbpp_ram
module tile_background_pixel_pipeline (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic          cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tbpp_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tbpp_pkg::out_t out_data_o
);
  import tbpp_pkg::*;

  logic        pat_sel_q, vmirror_q;
  logic [14:0] v_q, v_d, t_q, t_d;
  logic [8:0]  dot_q, dot_d, line_q, line_d;
  logic [7:0]  pat_lo_q, pat_lo_d, pat_hi_q, pat_hi_d;
  logic [15:0] shift_lo_q, shift_lo_d, shift_hi_q, shift_hi_d;
  logic [1:0]  pal_sel_q, pal_sel_d;
  logic        vblank_q, vblank_d;
  logic        out_valid_q;
  out_t        out_q, out_d;
  fetch_t      fetch_q, fetch_d;

  logic [7:0] tile_slots_q [TileSlots];
  logic [7:0] attr_slots_q [TileSlots];
  logic [7:0] palette_q [PaletteBytes];

  logic in_fire;
  in_t  in_w;
  assign in_w       = in_data_i;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  logic tick, visible, late_fetch, pre_fetch;
  logic [8:0] dm1, d257, d321;
  logic [2:0] phase;
  logic [SlotAw-1:0] slot;
  logic fetch_en;
  logic [14:0] fv, v_copy;
  logic [11:0] nt_a;
  logic [NtAw-1:0] nt_raddr;
  logic [PtAw-1:0] pt_raddr;
  logic nt_re, pt_re;
  logic [7:0] nt_rdata, pt_rdata, hi_fwd, attr_byte;
  logic [2:0] sh;
  logic [1:0] pix2, pal_use;
  logic [3:0] pal_idx;

  assign tick       = in_fire && (in_w.kind == KIND_TICK);
  assign visible    = (line_q < VisLines) && (dot_q >= 9'd1) && (dot_q <= 9'd256);
  assign late_fetch = (dot_q >= 9'd257) && (dot_q <= 9'd320);
  assign pre_fetch  = (dot_q >= 9'd321) && (dot_q <= 9'd336);
  assign dm1        = dot_q - 9'd1;
  assign d257       = dot_q - 9'd257;
  assign d321       = dot_q - 9'd321;
  assign v_copy     = (v_q & ~HorizMask) | (t_q & HorizMask);

  always_comb begin
    fetch_en = visible || late_fetch || pre_fetch;
    phase    = dm1[2:0];
    slot     = dm1[7:3];
    fv       = v_q;
    if (late_fetch) begin
      phase = d257[2:0];
      slot  = SlotAw'(d257[5:3]);
      if (dot_q == 9'd257) begin
        fv = v_copy;
      end
    end else if (pre_fetch) begin
      phase = d321[2:0];
      slot  = SlotAw'(d321[5:3]);
    end
  end

  // nametable address with mirroring; attribute address for phase 2
  always_comb begin
    if (phase == 3'd2) begin
      nt_a = {fv[11:10], 4'b1111, fv[9:7], fv[4:2]};
    end else begin
      nt_a = fv[11:0];
    end
    if (vmirror_q) begin
      nt_raddr = NtAw'(nt_a[10:0]);
    end else begin
      nt_raddr = NtAw'({nt_a[11], nt_a[9:0]});
    end
  end

  assign nt_re    = tick && fetch_en && (phase == 3'd0 || phase == 3'd2);
  assign pt_re    = tick && fetch_en && (phase == 3'd4 || phase == 3'd6);
  assign pt_raddr = PtAw'({pat_sel_q, tile_slots_q[slot], phase[1], fv[14:12]});

  tbpp_ram #(.Width(8), .Depth(NametableBytes)) u_nt_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_w.kind == KIND_NT_WR)),
    .waddr_i (in_w.addr[NtAw-1:0]),
    .wdata_i (in_w.data[7:0]),
    .re_i    (nt_re),
    .raddr_i (nt_raddr),
    .rdata_o (nt_rdata)
  );

  tbpp_ram #(.Width(8), .Depth(PatternBytes)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_w.kind == KIND_PAT_WR)),
    .waddr_i (in_w.addr[PtAw-1:0]),
    .wdata_i (in_w.data[7:0]),
    .re_i    (pt_re),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  // high pattern byte may still be in flight from the previous tick
  assign hi_fwd    = (fetch_q.valid && fetch_q.target == FETCH_HI) ? pt_rdata : pat_hi_q;
  assign pat_hi_d  = (fetch_q.valid && fetch_q.target == FETCH_HI) ? pt_rdata : pat_hi_q;
  assign pat_lo_d  = (fetch_q.valid && fetch_q.target == FETCH_LO) ? pt_rdata : pat_lo_q;
  assign attr_byte = attr_slots_q[slot];
  assign sh        = {fv[6], fv[1], 1'b0};

  always_comb begin
    fetch_d.valid  = nt_re || pt_re;
    fetch_d.slot   = slot;
    unique case (phase)
      3'd0:    fetch_d.target = FETCH_TILE;
      3'd2:    fetch_d.target = FETCH_ATTR;
      3'd4:    fetch_d.target = FETCH_LO;
      default: fetch_d.target = FETCH_HI;
    endcase
  end

  always_comb begin
    v_d        = v_q;
    t_d        = t_q;
    dot_d      = dot_q;
    line_d     = line_q;
    shift_lo_d = shift_lo_q;
    shift_hi_d = shift_hi_q;
    pal_sel_d  = pal_sel_q;
    vblank_d   = vblank_q;
    pix2       = 2'd0;
    pal_use    = pal_sel_q;
    pal_idx    = 4'd0;
    unique case (in_w.kind)
      KIND_LOAD_T: if (in_fire) t_d = in_w.data;
      KIND_LOAD_V: if (in_fire) v_d = in_w.data;
      KIND_TICK: if (in_fire) begin
        if (visible) begin
          shift_lo_d = {shift_lo_q[14:0], 1'b0};
          shift_hi_d = {shift_hi_q[14:0], 1'b0};
        end
        if (fetch_en && phase == 3'd7) begin
          shift_lo_d = {shift_lo_d[15:8], pat_lo_q};
          shift_hi_d = {shift_hi_d[15:8], hi_fwd};
          pal_sel_d  = 2'(attr_byte >> sh);
          pal_use    = pal_sel_d;
        end
        pix2    = {shift_hi_q[14], shift_lo_q[14]};
        pal_idx = (pix2 == 2'd0) ? 4'd0 : {pal_use, pix2};
        if (visible) begin
          if (phase == 3'd7) v_d = coarse_x_step(v_d);
          if (dot_q == 9'd256) v_d = fine_y_step(v_d);
        end
        if (late_fetch) begin
          if (dot_q == 9'd257) v_d = v_copy;
          if (phase == 3'd7) v_d = coarse_x_step(v_d);
        end
        if (line_q == VblankLine) vblank_d = 1'b1;
        if (line_q == LastLine) begin
          vblank_d = 1'b0;
          if (dot_q >= 9'd280 && dot_q <= 9'd304) begin
            v_d = (v_d & ~VertMask) | (t_q & VertMask);
          end
        end
        if (dot_q == LastDot) begin
          dot_d  = 9'd0;
          line_d = (line_q == LastLine) ? 9'd0 : line_q + 9'd1;
        end else begin
          dot_d  = dot_q + 9'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d.pixel_valid = (in_w.kind == KIND_TICK) && visible;
    out_d.pixel_x     = out_d.pixel_valid ? dm1[7:0] : 8'd0;
    out_d.pixel_y     = out_d.pixel_valid ? line_q[7:0] : 8'd0;
    out_d.colour      = out_d.pixel_valid ? palette_q[PalAw'(pal_idx)] : 8'd0;
    out_d.vblank      = vblank_d;
    out_d.dot_now     = dot_d;
    out_d.line_now    = line_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_sel_q   <= 1'b0;
      vmirror_q   <= 1'b0;
      v_q         <= '0;
      t_q         <= '0;
      dot_q       <= '0;
      line_q      <= '0;
      pat_lo_q    <= '0;
      pat_hi_q    <= '0;
      shift_lo_q  <= '0;
      shift_hi_q  <= '0;
      pal_sel_q   <= '0;
      vblank_q    <= 1'b0;
      out_valid_q <= 1'b0;
      fetch_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PATTERN_SELECT: pat_sel_q <= cfg_data_i;
          CFG_VERT_MIRROR:    vmirror_q <= cfg_data_i;
        endcase
      end
      v_q        <= v_d;
      t_q        <= t_d;
      dot_q      <= dot_d;
      line_q     <= line_d;
      pat_lo_q   <= pat_lo_d;
      pat_hi_q   <= pat_hi_d;
      shift_lo_q <= shift_lo_d;
      shift_hi_q <= shift_hi_d;
      pal_sel_q  <= pal_sel_d;
      vblank_q   <= vblank_d;
      fetch_q    <= fetch_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
    if (in_fire && in_w.kind == KIND_PAL_WR) begin
      palette_q[in_w.addr[PalAw-1:0]] <= in_w.data[7:0];
    end
    if (fetch_q.valid && fetch_q.target == FETCH_TILE) begin
      tile_slots_q[fetch_q.slot] <= nt_rdata;
    end
    if (fetch_q.valid && fetch_q.target == FETCH_ATTR) begin
      attr_slots_q[fetch_q.slot] <= nt_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o) else $error("ready low with empty output register");
  a_dot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_q < DotsPerLine) else $error("dot counter out of range");
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q < LinesPerFrame) else $error("line counter out of range");
  a_fetch_follows_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick && fetch_en && (phase == 3'd0) |=> fetch_q.valid && fetch_q.target == FETCH_TILE)
    else $error("tile fetch not tracked");
  a_pixel_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pixel_valid |-> out_q.pixel_y < 8'd240)
    else $error("pixel outside visible lines");
`endif

endmodule
